// ===== hw/rtl/pre_pkg.sv =====
// Shared types and constants for the palette row expander.
package pre_pkg;

  localparam int unsigned PALETTE_DEPTH = 256;
  localparam int unsigned IDX_W = 8;
  localparam int unsigned COL_W = 13;
  localparam logic [COL_W-1:0] MAX_ROW_PIXELS = 13'd4096;

  // depth_mode codes
  localparam logic [2:0] DEPTH_1 = 3'd0;
  localparam logic [2:0] DEPTH_2 = 3'd1;
  localparam logic [2:0] DEPTH_4 = 3'd2;
  localparam logic [2:0] DEPTH_8 = 3'd3;
  localparam logic [2:0] DEPTH_16 = 3'd4;

  // configuration register indexes
  localparam logic [1:0] CFG_DEPTH_MODE = 2'd0;
  localparam logic [1:0] CFG_ALPHA_PRESENT = 2'd1;
  localparam logic [1:0] CFG_ROW_PIXELS = 2'd2;

  // action codes
  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_DATA = 1'b1;

  localparam logic [7:0] ALPHA_OPAQUE = 8'hff;
  localparam logic [7:0] ALPHA_CLEAR = 8'h00;

  // one pixel leaving the unpacker
  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic [7:0]       alpha;
    logic             row_done;
    logic             run_last;
    logic             status;
  } pix_t;

  // palette write request
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    logic [23:0]      data;
  } pal_wr_t;

endpackage

// ===== hw/rtl/pre_unpack.sv =====
// Input stage: holds one item, unpacks data bytes into pixels, tracks row position.
module pre_unpack (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [2:0]                depth_mode,
  input  logic                      alpha_present,
  input  logic [pre_pkg::COL_W-1:0] row_pixels,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      action,
  input  logic [7:0]                entry_index,
  input  logic [7:0]                entry_red,
  input  logic [7:0]                entry_green,
  input  logic [7:0]                entry_blue,
  input  logic [7:0]                data_byte,
  output logic                      pix_valid,
  input  logic                      pix_ready,
  output pre_pkg::pix_t             pix,
  output pre_pkg::pal_wr_t          pal_wr
);

  logic                      u_valid;
  logic                      u_action;
  logic [7:0]                u_index;
  logic [23:0]               u_rgb;
  logic [7:0]                u_byte;
  logic [2:0]                pos;
  logic [pre_pkg::COL_W-1:0] col;
  logic [7:0]                pend;
  logic                      phase;

  logic                      unsup;
  logic                      index_only;
  logic                      u_done;
  logic                      accept;
  logic                      fire;
  logic [pre_pkg::COL_W-1:0] limit;
  logic                      row_end;
  logic [2:0]                last_pos;
  logic [2:0]                shamt;
  logic [7:0]                sh;
  logic [7:0]                idx;
  logic [7:0]                alpha;

  // decode mode combination
  assign unsup = (depth_mode > pre_pkg::DEPTH_16) ||
                 ((depth_mode == pre_pkg::DEPTH_16) && !alpha_present) ||
                 ((depth_mode == pre_pkg::DEPTH_4) && alpha_present);
  assign index_only = !unsup && (depth_mode == pre_pkg::DEPTH_16) && !phase;

  // row length, clamped to 1..MAX_ROW_PIXELS
  always_comb begin
    if (row_pixels == '0) begin
      limit = pre_pkg::COL_W'(1);
    end else if (row_pixels > pre_pkg::MAX_ROW_PIXELS) begin
      limit = pre_pkg::MAX_ROW_PIXELS;
    end else begin
      limit = row_pixels;
    end
  end
  assign row_end = ({1'b0, col} + 14'd1) >= {1'b0, limit};

  // select the pixel at the current position
  assign shamt = 3'({1'b0, pos} << depth_mode[1:0]);
  assign sh = 8'(u_byte << shamt);

  always_comb begin
    idx = u_byte;
    alpha = pre_pkg::ALPHA_OPAQUE;
    last_pos = 3'd0;
    unique case (depth_mode)
      pre_pkg::DEPTH_1: begin
        idx = {7'd0, sh[7]};
        last_pos = 3'd7;
      end
      pre_pkg::DEPTH_2: begin
        last_pos = 3'd3;
        if (alpha_present) begin
          idx = {7'd0, sh[7]};
          alpha = sh[6] ? pre_pkg::ALPHA_OPAQUE : pre_pkg::ALPHA_CLEAR;
        end else begin
          idx = {6'd0, sh[7:6]};
        end
      end
      pre_pkg::DEPTH_4: begin
        idx = {4'd0, sh[7:4]};
        last_pos = 3'd1;
      end
      pre_pkg::DEPTH_8: begin
        if (alpha_present) begin
          idx = {4'd0, u_byte[7:4]};
          alpha = {u_byte[3:0], u_byte[3:0]};
        end
      end
      pre_pkg::DEPTH_16: begin
        idx = pend;
        alpha = u_byte;
      end
      default: begin
        idx = u_byte;
      end
    endcase
  end

  // build the pixel beat
  always_comb begin
    pix = '0;
    if (unsup) begin
      pix.status = 1'b1;
      pix.run_last = 1'b1;
    end else begin
      pix.idx = idx;
      pix.alpha = alpha;
      pix.row_done = row_end;
      pix.run_last = row_end || (pos == last_pos);
    end
  end

  assign pix_valid = u_valid && (u_action == pre_pkg::ACT_DATA) && !index_only;
  assign fire = pix_valid && pix_ready;
  assign u_done = u_valid && ((u_action == pre_pkg::ACT_LOAD) || index_only ||
                              (fire && pix.run_last));
  assign in_stall = u_valid && !u_done;
  assign accept = in_valid && !in_stall;

  // palette write leaves in the single cycle a load item sits here
  assign pal_wr.en = u_valid && (u_action == pre_pkg::ACT_LOAD);
  assign pal_wr.addr = u_index;
  assign pal_wr.data = u_rgb;

  // hold the item and advance through its pixels
  always_ff @(posedge clk) begin
    if (rst) begin
      u_valid <= 1'b0;
      pos <= '0;
      col <= '0;
      pend <= '0;
      phase <= 1'b0;
    end else begin
      if (accept) begin
        u_valid <= 1'b1;
        pos <= '0;
      end else if (u_done) begin
        u_valid <= 1'b0;
      end else if (fire) begin
        pos <= pos + 3'd1;
      end
      if (u_valid && (u_action == pre_pkg::ACT_DATA) && index_only) begin
        pend <= u_byte;
        phase <= 1'b1;
      end
      if (fire && !unsup) begin
        col <= row_end ? '0 : col + pre_pkg::COL_W'(1);
        if (depth_mode == pre_pkg::DEPTH_16) begin
          phase <= 1'b0;
        end
      end
    end
  end

  // capture payload
  always_ff @(posedge clk) begin
    if (accept) begin
      u_action <= action;
      u_index <= entry_index;
      u_rgb <= {entry_red, entry_green, entry_blue};
      u_byte <= data_byte;
    end
  end

endmodule

// ===== hw/rtl/palette_row_expander_top.sv =====
// Palette row expander: config registers, palette store and output register.
// A data byte is held in the input stage; each pixel then passes the output register.
// Throughput: one pixel per cycle unless out_stall holds it; a data byte holds the input
// until its last pixel is taken (up to 8 at 1 bit per pixel), bounded by the single output port.
// Load items and the index byte of a 16-bit pair give no beat and never stall the input.
// Reset clears control state and sets depth 8, no alpha, row of 1; palette stays unset.
module palette_row_expander_top (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [1:0]                cfg_index,
  input  logic [12:0]               cfg_data,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      action,
  input  logic [7:0]                entry_index,
  input  logic [7:0]                entry_red,
  input  logic [7:0]                entry_green,
  input  logic [7:0]                entry_blue,
  input  logic [7:0]                data_byte,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [7:0]                pixel_red,
  output logic [7:0]                pixel_green,
  output logic [7:0]                pixel_blue,
  output logic [7:0]                pixel_alpha,
  output logic                      row_done,
  output logic                      run_last,
  output logic                      status
);

  logic [2:0]                depth_mode;
  logic                      alpha_present;
  logic [pre_pkg::COL_W-1:0] row_pixels;

  logic                      pix_valid;
  logic                      pix_ready;
  pre_pkg::pix_t             pix;
  pre_pkg::pal_wr_t          pal_wr;

  logic [23:0]               palette [pre_pkg::PALETTE_DEPTH];
  logic [23:0]               rd_q;
  logic                      r_valid;
  pre_pkg::pix_t             r_meta;

  assign cfg_ready = 1'b1;

  // write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      depth_mode <= pre_pkg::DEPTH_8;
      alpha_present <= 1'b0;
      row_pixels <= pre_pkg::COL_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        pre_pkg::CFG_DEPTH_MODE:    depth_mode <= cfg_data[2:0];
        pre_pkg::CFG_ALPHA_PRESENT: alpha_present <= cfg_data[0];
        pre_pkg::CFG_ROW_PIXELS:    row_pixels <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  pre_unpack u_unpack (
    .clk           (clk),
    .rst           (rst),
    .depth_mode    (depth_mode),
    .alpha_present (alpha_present),
    .row_pixels    (row_pixels),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .action        (action),
    .entry_index   (entry_index),
    .entry_red     (entry_red),
    .entry_green   (entry_green),
    .entry_blue    (entry_blue),
    .data_byte     (data_byte),
    .pix_valid     (pix_valid),
    .pix_ready     (pix_ready),
    .pix           (pix),
    .pal_wr        (pal_wr)
  );

  // output register advances when empty or drained
  assign pix_ready = !r_valid || !out_stall;

  // palette store: write loads, read once as a pixel enters the output register
  always_ff @(posedge clk) begin
    if (pal_wr.en) begin
      palette[pal_wr.addr] <= pal_wr.data;
    end
    if (pix_valid && pix_ready) begin
      rd_q <= palette[pix.idx];
    end
  end

  // hold the result beat
  always_ff @(posedge clk) begin
    if (rst) begin
      r_valid <= 1'b0;
    end else if (pix_ready) begin
      r_valid <= pix_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pix_valid && pix_ready) begin
      r_meta <= pix;
    end
  end

  // drive result fields; an unsupported mode beat carries zero color
  assign out_valid = r_valid;
  assign pixel_red = r_meta.status ? 8'd0 : rd_q[23:16];
  assign pixel_green = r_meta.status ? 8'd0 : rd_q[15:8];
  assign pixel_blue = r_meta.status ? 8'd0 : rd_q[7:0];
  assign pixel_alpha = r_meta.alpha;
  assign row_done = r_meta.row_done;
  assign run_last = r_meta.run_last;
  assign status = r_meta.status;

endmodule

// ===== sim/tb_palette_row_expander_top.sv =====
// Self-checking testbench for the palette row expander with a predicting scoreboard.
module tb_palette_row_expander_top;

  localparam int unsigned CYCLE_LIMIT = 400000;

  // one expanded pixel as it leaves the block
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       row_done;
    logic       run_last;
    logic       status;
  } rgba_beat_t;

  // predicts expanded pixels and checks them in order
  class pixel_scoreboard;
    logic [23:0] palette [pre_pkg::PALETTE_DEPTH];
    logic [2:0]  depth;
    logic        alpha_on;
    logic [12:0] rows;
    int unsigned col;
    logic [7:0]  held_index;
    logic        second_byte;
    rgba_beat_t  expected_pixels [$];
    int          failures;

    function new();
      depth       = pre_pkg::DEPTH_8;
      alpha_on    = 1'b0;
      rows        = 13'd1;
      col         = 0;
      held_index  = 8'h00;
      second_byte = 1'b0;
      failures    = 0;
    endfunction

    function int outstanding();
      return expected_pixels.size();
    endfunction

    function void apply_reg(logic [1:0] idx, logic [12:0] val);
      case (idx)
        pre_pkg::CFG_DEPTH_MODE: depth = val[2:0];
        pre_pkg::CFG_ALPHA_PRESENT: alpha_on = val[0];
        pre_pkg::CFG_ROW_PIXELS: rows = val;
        default: ;
      endcase
    endfunction

    // look up one pixel and advance the column
    function rgba_beat_t make_pixel(logic [7:0] idx, logic [7:0] a);
      rgba_beat_t px;
      int unsigned lim;
      lim = rows;
      if (lim == 0) lim = 1;
      if (lim > pre_pkg::MAX_ROW_PIXELS) lim = pre_pkg::MAX_ROW_PIXELS;
      px.red      = palette[idx][23:16];
      px.green    = palette[idx][15:8];
      px.blue     = palette[idx][7:0];
      px.alpha    = a;
      px.row_done = (col + 1 >= lim);
      px.run_last = 1'b0;
      px.status   = 1'b0;
      col = px.row_done ? 0 : col + 1;
      return px;
    endfunction

    // expand one accepted input beat into expected pixels
    function void take_beat(logic act, logic [7:0] eidx, logic [7:0] er, logic [7:0] eg,
                            logic [7:0] eb, logic [7:0] db);
      rgba_beat_t  run [8];
      int          n;
      int unsigned bits;
      int unsigned per;
      logic [7:0]  idx;
      logic [7:0]  a;
      n = 0;
      if (act == pre_pkg::ACT_LOAD) begin
        palette[eidx] = {er, eg, eb};
        return;
      end
      if (depth > pre_pkg::DEPTH_16 || (depth == pre_pkg::DEPTH_16 && !alpha_on) ||
          (depth == pre_pkg::DEPTH_4 && alpha_on)) begin
        run[0] = '0;
        run[0].status = 1'b1;
        n = 1;
      end else if (depth == pre_pkg::DEPTH_16) begin
        if (!second_byte) begin
          held_index  = db;
          second_byte = 1'b1;
        end else begin
          second_byte = 1'b0;
          run[0] = make_pixel(held_index, db);
          n = 1;
        end
      end else if (depth == pre_pkg::DEPTH_8 && alpha_on) begin
        run[0] = make_pixel({4'h0, db[7:4]}, {db[3:0], db[3:0]});
        n = 1;
      end else begin
        bits = 1 << depth;
        per  = 8 / bits;
        for (int unsigned p = 0; p < per; p++) begin
          idx = 8'((db >> (8 - bits * (p + 1))) & ((1 << bits) - 1));
          a   = pre_pkg::ALPHA_OPAQUE;
          if (depth == pre_pkg::DEPTH_2 && alpha_on) begin
            a   = idx[0] ? pre_pkg::ALPHA_OPAQUE : pre_pkg::ALPHA_CLEAR;
            idx = idx >> 1;
          end
          run[n] = make_pixel(idx, a);
          n++;
          if (run[n-1].row_done) break;
        end
      end
      if (n > 0) run[n-1].run_last = 1'b1;
      for (int i = 0; i < n; i++) expected_pixels.push_back(run[i]);
    endfunction

    // compare one accepted pixel with the oldest expectation
    function void check_pixel(rgba_beat_t got);
      rgba_beat_t want;
      if (expected_pixels.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("unexpected pixel r=%h g=%h b=%h a=%h done=%b last=%b st=%b",
                   got.red, got.green, got.blue, got.alpha, got.row_done,
                   got.run_last, got.status);
        return;
      end
      want = expected_pixels.pop_front();
      if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue ||
          got.alpha !== want.alpha || got.row_done !== want.row_done ||
          got.run_last !== want.run_last || got.status !== want.status) begin
        failures++;
        if (failures <= 10)
          $display("pixel mismatch exp r=%h g=%h b=%h a=%h d=%b l=%b s=%b",
                   want.red, want.green, want.blue, want.alpha, want.row_done,
                   want.run_last, want.status,
                   " got r=%h g=%h b=%h a=%h d=%b l=%b s=%b",
                   got.red, got.green, got.blue,
                   got.alpha, got.row_done, got.run_last, got.status);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [12:0] cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic        action;
  logic [7:0]  entry_index;
  logic [7:0]  entry_red;
  logic [7:0]  entry_green;
  logic [7:0]  entry_blue;
  logic [7:0]  data_byte;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  pixel_red;
  logic [7:0]  pixel_green;
  logic [7:0]  pixel_blue;
  logic [7:0]  pixel_alpha;
  logic        row_done;
  logic        run_last;
  logic        status;

  pixel_scoreboard sb;
  logic            quiet;
  int unsigned     cycles;

  palette_row_expander_top dut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .action(action),
    .entry_index(entry_index),
    .entry_red(entry_red),
    .entry_green(entry_green),
    .entry_blue(entry_blue),
    .data_byte(data_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .pixel_red(pixel_red),
    .pixel_green(pixel_green),
    .pixel_blue(pixel_blue),
    .pixel_alpha(pixel_alpha),
    .row_done(row_done),
    .run_last(run_last),
    .status(status)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // stop a hung run
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // check every pixel beat the sink takes
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_pixel({pixel_red, pixel_green, pixel_blue, pixel_alpha,
                      row_done, run_last, status});
  end

  // stall the sink at random before each beat; quiet phases never stall it
  initial begin : sink_pacing
    int hold;
    out_stall = 1'b0;
    @(negedge rst);
    @(negedge clk);
    forever begin
      hold = quiet ? 0 : $urandom_range(0, 14);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      @(negedge clk);
    end
  end

  // write one register; only called while the block is idle
  task automatic write_reg(input logic [1:0] idx, input logic [12:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.apply_reg(idx, val);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // set all registers; junk rides in the unused upper bits
  task automatic configure(input logic [2:0] mode, input logic a, input logic [12:0] len);
    logic [12:0] word;
    word = 13'($urandom);
    word[2:0] = mode;
    write_reg(pre_pkg::CFG_DEPTH_MODE, word);
    word = 13'($urandom);
    word[0] = a;
    write_reg(pre_pkg::CFG_ALPHA_PRESENT, word);
    write_reg(pre_pkg::CFG_ROW_PIXELS, len);
  endtask

  // drop the input, wait until every expected pixel has left, then let the pipeline drain
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.outstanding() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // offer one input beat after a random gap and wait for it to be taken
  task automatic push_beat(input logic act, input logic [7:0] e, input logic [7:0] r,
                           input logic [7:0] g, input logic [7:0] b, input logic [7:0] db);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) begin
        action      <= 1'($urandom);
        entry_index <= 8'($urandom);
        entry_red   <= 8'($urandom);
        entry_green <= 8'($urandom);
        entry_blue  <= 8'($urandom);
        data_byte   <= 8'($urandom);
        @(negedge clk);
      end
    end
    in_valid    <= 1'b1;
    action      <= act;
    entry_index <= e;
    entry_red   <= r;
    entry_green <= g;
    entry_blue  <= b;
    data_byte   <= db;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.take_beat(act, e, r, g, b, db);
    @(negedge clk);
  endtask

  task automatic send_load(input logic [7:0] e, input logic [7:0] r, input logic [7:0] g,
                           input logic [7:0] b);
    push_beat(pre_pkg::ACT_LOAD, e, r, g, b, 8'($urandom));
  endtask

  task automatic send_data(input logic [7:0] db);
    push_beat(pre_pkg::ACT_DATA, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), db);
  endtask

  initial begin : stimulus
    int          sent;
    int          len;
    int          pick;
    logic [2:0]  mode;
    logic        a;
    logic [12:0] rowlen;
    sb          = new();
    quiet       = 1'b0;
    cycles      = 0;
    rst         = 1'b1;
    cfg_valid   = 1'b0;
    cfg_index   = pre_pkg::CFG_DEPTH_MODE;
    cfg_data    = '0;
    in_valid    = 1'b0;
    action      = pre_pkg::ACT_LOAD;
    entry_index = '0;
    entry_red   = '0;
    entry_green = '0;
    entry_blue  = '0;
    data_byte   = '0;
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // fill the whole palette so that no pixel reads an unset entry
    send_load(8'h00, 8'h00, 8'h00, 8'h00);
    for (int i = 1; i < 255; i++)
      send_load(8'(i), 8'($urandom), 8'($urandom), 8'($urandom));
    send_load(8'hff, 8'hff, 8'hff, 8'hff);

    // reset settings: 8-bit index, no alpha, one pixel per row
    send_data(8'h00);
    send_data(8'hff);
    send_data(8'h5a);

    // 1-bit with alpha set is opaque; row length zero acts as one
    settle();
    configure(pre_pkg::DEPTH_1, 1'b1, 13'd0);
    send_data(8'ha5);

    // ragged row drops the padding bits
    settle();
    configure(pre_pkg::DEPTH_1, 1'b0, 13'd3);
    send_data(8'hff);

    // shrink the row in mid-row: the next pixel closes it
    settle();
    configure(pre_pkg::DEPTH_1, 1'b0, 13'd12);
    send_data(8'h96);
    settle();
    write_reg(pre_pkg::CFG_ROW_PIXELS, 13'd5);
    send_data(8'h3c);

    // 2-bit plain and with alpha flag
    settle();
    configure(pre_pkg::DEPTH_2, 1'b0, 13'd4);
    send_data(8'he4);
    settle();
    configure(pre_pkg::DEPTH_2, 1'b1, 13'd4);
    send_data(8'h1b);
    send_data(8'he4);

    // 4-bit plain
    settle();
    configure(pre_pkg::DEPTH_4, 1'b0, 13'd2);
    send_data(8'hf0);

    // 8-bit with alpha nibble; oversized row saturates
    settle();
    configure(pre_pkg::DEPTH_8, 1'b1, 13'h1fff);
    send_data(8'hff);
    send_data(8'h0a);

    // 16-bit index and alpha pairs
    settle();
    configure(pre_pkg::DEPTH_16, 1'b1, 13'd2);
    send_data(8'hff);
    send_data(8'h00);
    send_data(8'h00);
    send_data(8'hff);
    send_data(8'h80);

    // unsupported mode between the two bytes of a pair leaves the pair intact
    settle();
    write_reg(pre_pkg::CFG_ALPHA_PRESENT, 13'd0);
    send_data(8'h11);
    settle();
    write_reg(pre_pkg::CFG_ALPHA_PRESENT, 13'd1);
    send_data(8'h7f);

    // remaining unsupported combinations and the unused register slot
    settle();
    configure(pre_pkg::DEPTH_4, 1'b1, 13'd1);
    send_data(8'h33);
    settle();
    configure(3'd5, 1'b0, 13'd1);
    send_data(8'h44);
    settle();
    configure(3'd7, 1'b1, 13'd1);
    send_data(8'h55);
    settle();
    write_reg(2'd3, 13'($urandom));

    // random phases: mostly supported modes, a few unsupported
    sent = 0;
    while (sent < 180) begin
      settle();
      quiet = ($urandom_range(0, 3) == 0);
      pick  = $urandom_range(0, 19);
      if (pick < 17) begin
        mode = 3'($urandom_range(0, 4));
        a    = 1'($urandom);
        if (mode == pre_pkg::DEPTH_4) a = 1'b0;
        if (mode == pre_pkg::DEPTH_16) a = 1'b1;
      end else if (pick == 17) begin
        mode = 3'($urandom_range(5, 7));
        a    = 1'($urandom);
      end else begin
        mode = (pick == 18) ? pre_pkg::DEPTH_4 : pre_pkg::DEPTH_16;
        a    = (pick == 18);
      end
      case ($urandom_range(0, 9))
        0: rowlen = 13'd0;
        1: rowlen = 13'($urandom_range(4096, 8191));
        2: rowlen = pre_pkg::MAX_ROW_PIXELS;
        default: rowlen = 13'($urandom_range(1, 24));
      endcase
      configure(mode, a, rowlen);
      if ($urandom_range(0, 7) == 0) write_reg(2'd3, 13'($urandom));
      len = $urandom_range(6, 20);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 9) == 0)
          send_load(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        else
          send_data(8'($urandom));
        sent++;
      end
    end

    // drain and report
    in_valid <= 1'b0;
    quiet = 1'b0;
    while (sb.outstanding() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (sb.failures == 0 && sb.outstanding() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
